// File: hdl/gcmf_pkg.sv
`default_nettype none
package gcmf_pkg;

   localparam int unsigned CAP_W  = 16;
   localparam int unsigned RES_W  = 17;
   localparam int unsigned FLOW_W = 24;
   localparam int unsigned SIZE_W = 5;

   // directions; the opposite direction is the code with bit 0 flipped
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   localparam logic PH_TRACE = 1'b0;
   localparam logic PH_AUG   = 1'b1;

   typedef enum logic [2:0] {
      REG_ROWS     = 3'd0,
      REG_COLS     = 3'd1,
      REG_SRC_CAP  = 3'd2,
      REG_SINK_CAP = 3'd3,
      REG_NBR_CAP  = 3'd4
   } reg_type;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_COPY     = 8'b0000_0010,
      ST_COPY_END = 8'b0000_0100,
      ST_INIT     = 8'b0000_1000,
      ST_SEED     = 8'b0001_0000,
      ST_GROW     = 8'b0010_0000,
      ST_SCAN     = 8'b0100_0000,
      ST_TRACE    = 8'b1000_0000
   } state_type;

   // path token handed from a cell to one neighbor
   typedef struct packed {
      logic             valid;
      logic             phase;
      logic [1:0]       travel;
      logic [CAP_W-1:0] x;
   } msg_type;

   typedef struct packed {
      logic             init;
      logic             seed;
      logic             grow;
      logic [CAP_W-1:0] src_cap;
      logic [CAP_W-1:0] sink_cap;
      logic [CAP_W-1:0] nbr_cap;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// File: hdl/gcmf_ram.sv
`default_nettype none
module gcmf_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                           wdata,
   input  wire logic                                       re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                           rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

// File: hdl/gcmf_cell.sv
`default_nettype none
module gcmf_cell #(
   parameter int unsigned ROW_W   = 5,
   parameter int unsigned COL_W   = 5,
   parameter int unsigned ROW_POS = 0,
   parameter int unsigned COL_POS = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gcmf_pkg::cell_ctrl_type       ctrl,
   input  wire logic [ROW_W-1:0]              rows,
   input  wire logic [COL_W-1:0]              cols,
   input  wire logic                          label_we,
   input  wire logic                          label_in,
   input  wire logic                          start,
   input  wire gcmf_pkg::msg_type [3:0]       msg_in,
   input  wire logic [3:0]                    reach_in,
   output gcmf_pkg::msg_type                  msg_out,
   output logic [3:0]                         reach_out,
   output logic                               found,
   output logic                               grow_cand,
   output logic                               done,
   output logic [gcmf_pkg::CAP_W-1:0]         done_x
);
   localparam logic [ROW_W-1:0] MY_ROW = ROW_W'(ROW_POS);
   localparam logic [COL_W-1:0] MY_COL = COL_W'(COL_POS);

   logic                        label_ff;
   logic [gcmf_pkg::CAP_W-1:0]  term_ff;
   logic [gcmf_pkg::RES_W-1:0]  res_ff [4];
   logic                        visit_ff;
   logic                        src_ff;
   logic [1:0]                  pred_ff;
   logic [1:0]                  succ_ff;
   logic                        tok_ff;
   logic                        phase_ff;
   logic [gcmf_pkg::CAP_W-1:0]  x_ff;
   logic                        end_ff;
   logic                        done_ff;
   logic [gcmf_pkg::CAP_W-1:0]  done_x_ff;

   logic                        active;
   logic                        has_down;
   logic                        has_right;
   logic                        rx_hit;
   logic [1:0]                  rx_side;
   logic [gcmf_pkg::CAP_W-1:0]  rx_x;
   logic                        rx_phase;
   logic [1:0]                  grow_side;
   logic [gcmf_pkg::CAP_W-1:0]  x_src;
   logic [gcmf_pkg::RES_W-1:0]  rx_res;
   logic [gcmf_pkg::RES_W-1:0]  nbr_init;

   assign active    = (MY_ROW < rows) && (MY_COL < cols);
   assign has_down  = ({1'b0, MY_ROW} + 1'b1) < {1'b0, rows};
   assign has_right = ({1'b0, MY_COL} + 1'b1) < {1'b0, cols};
   assign nbr_init  = gcmf_pkg::RES_W'(ctrl.nbr_cap);
   assign x_src     = (term_ff < x_ff) ? term_ff : x_ff;

   // a neighbor on side s aims at this cell when it travels the opposite way
   always_comb begin
      rx_hit   = 1'b0;
      rx_side  = gcmf_pkg::DIR_UP;
      rx_x     = '0;
      rx_phase = gcmf_pkg::PH_TRACE;
      for (int s = 0; s < 4; s++) begin
         if (msg_in[s].valid && (msg_in[s].travel == (2'(s) ^ 2'd1))) begin
            rx_hit   = 1'b1;
            rx_side  = 2'(s);
            rx_x     = msg_in[s].x;
            rx_phase = msg_in[s].phase;
         end
      end
   end

   always_comb begin
      grow_side = gcmf_pkg::DIR_UP;
      for (int s = 3; s >= 0; s--) begin
         if (reach_in[s]) begin
            grow_side = 2'(s);
         end
      end
   end

   assign rx_res    = res_ff[rx_side];
   assign grow_cand = active && !visit_ff && (|reach_in);
   assign found     = visit_ff && label_ff && (term_ff != '0);
   assign done      = done_ff;
   assign done_x    = done_ff ? done_x_ff : '0;

   always_comb begin
      for (int d = 0; d < 4; d++) begin
         reach_out[d] = visit_ff && (res_ff[d] != '0);
      end
   end

   always_comb begin
      msg_out = '0;
      if (tok_ff) begin
         msg_out.valid = 1'b1;
         if (phase_ff == gcmf_pkg::PH_TRACE && !src_ff) begin
            // walk back toward the source, carrying the running bottleneck
            msg_out.phase  = gcmf_pkg::PH_TRACE;
            msg_out.travel = pred_ff;
            msg_out.x      = x_ff;
         end else if (phase_ff == gcmf_pkg::PH_TRACE) begin
            msg_out.phase  = gcmf_pkg::PH_AUG;
            msg_out.travel = succ_ff;
            msg_out.x      = x_src;
         end else begin
            msg_out.phase  = gcmf_pkg::PH_AUG;
            msg_out.travel = succ_ff;
            msg_out.x      = x_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (label_we) begin
         label_ff <= label_in;
      end
      if (ctrl.init) begin
         term_ff <= !active ? '0 : (label_ff ? ctrl.sink_cap : ctrl.src_cap);
         res_ff[gcmf_pkg::DIR_UP]    <= (active && MY_ROW != '0) ? nbr_init : '0;
         res_ff[gcmf_pkg::DIR_DOWN]  <= (active && has_down) ? nbr_init : '0;
         res_ff[gcmf_pkg::DIR_LEFT]  <= (active && MY_COL != '0) ? nbr_init : '0;
         res_ff[gcmf_pkg::DIR_RIGHT] <= (active && has_right) ? nbr_init : '0;
      end else if (rx_hit && rx_phase == gcmf_pkg::PH_AUG) begin
         res_ff[rx_side] <= rx_res + gcmf_pkg::RES_W'(rx_x);
         if (end_ff) begin
            term_ff <= term_ff - rx_x;
         end
      end else if (tok_ff && phase_ff == gcmf_pkg::PH_TRACE && src_ff) begin
         term_ff          <= term_ff - x_src;
         res_ff[succ_ff]  <= res_ff[succ_ff] - gcmf_pkg::RES_W'(x_src);
      end else if (tok_ff && phase_ff == gcmf_pkg::PH_AUG) begin
         res_ff[succ_ff]  <= res_ff[succ_ff] - gcmf_pkg::RES_W'(x_ff);
      end
      if (ctrl.seed) begin
         src_ff <= 1'b1;
      end else if (ctrl.grow && grow_cand) begin
         src_ff  <= 1'b0;
         pred_ff <= grow_side;
      end
      if (start) begin
         phase_ff <= gcmf_pkg::PH_TRACE;
         x_ff     <= term_ff;
      end else if (rx_hit && rx_phase == gcmf_pkg::PH_TRACE) begin
         phase_ff <= gcmf_pkg::PH_TRACE;
         x_ff     <= (gcmf_pkg::RES_W'(rx_x) <= rx_res) ? rx_x : rx_res[gcmf_pkg::CAP_W-1:0];
         succ_ff  <= rx_side;
      end else if (rx_hit) begin
         phase_ff  <= gcmf_pkg::PH_AUG;
         x_ff      <= rx_x;
         done_x_ff <= rx_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visit_ff <= 1'b0;
         tok_ff   <= 1'b0;
         end_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.seed) begin
            visit_ff <= active && !label_ff && (term_ff != '0);
            end_ff   <= 1'b0;
            tok_ff   <= 1'b0;
         end else if (ctrl.grow && grow_cand) begin
            visit_ff <= 1'b1;
         end
         if (start) begin
            tok_ff <= 1'b1;
            end_ff <= 1'b1;
         end else if (rx_hit) begin
            if (rx_phase == gcmf_pkg::PH_AUG && end_ff) begin
               tok_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               tok_ff <= 1'b1;
            end
         end else if (tok_ff) begin
            tok_ff <= 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

// File: hdl/grid_graph_cut_max_flow.sv
`default_nettype none
// pixels load one per cycle while busy is low; the solve then copies the labels into
// the cell array, initializes the cells and, for each augmenting path, runs the
// wavefront search through the cell grid, the scan for a cell that reached the sink
// and the token walk along the path
// the result strobes for one cycle when no path is left; busy is high during the solve
// reset clears control state and loads the register defaults; the grid starts empty
module grid_graph_cut_max_flow #(
   parameter int unsigned MAX_ROWS = 16,
   parameter int unsigned MAX_COLS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_is_black,
   output logic             rsp_strobe,
   output logic [23:0]      rsp_max_flow,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
   localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
   localparam int unsigned CW    = $clog2(MAX_COLS + 1);
   localparam int unsigned NW    = $clog2(CELLS + 1);
   localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

   logic [gcmf_pkg::SIZE_W-1:0] rows_cfg_ff;
   logic [gcmf_pkg::SIZE_W-1:0] cols_cfg_ff;
   logic [gcmf_pkg::CAP_W-1:0]  src_cap_ff;
   logic [gcmf_pkg::CAP_W-1:0]  sink_cap_ff;
   logic [gcmf_pkg::CAP_W-1:0]  nbr_cap_ff;

   gcmf_pkg::state_type         state_ff, state_in;
   logic [NW-1:0]               count_ff;
   logic [NW-1:0]               rd_p_ff;
   logic [RW-1:0]               rd_r_ff;
   logic [CW-1:0]               rd_c_ff;
   logic                        cp_valid_ff;
   logic [RW-1:0]               cp_r_ff;
   logic [CW-1:0]               cp_c_ff;
   logic [AW-1:0]               scan_ff;
   logic [gcmf_pkg::FLOW_W-1:0] flow_ff;

   logic [RW-1:0]               rows_eff;
   logic [CW-1:0]               cols_eff;
   logic [NW-1:0]               total;
   logic                        accept;
   logic                        csr_write;
   logic                        label_rd;
   gcmf_pkg::cell_ctrl_type     ctrl;
   logic                        scan_hit;
   logic                        any_found;
   logic                        any_grow;
   logic                        any_done;
   logic [gcmf_pkg::CAP_W-1:0]  done_gather;

   gcmf_pkg::msg_type           msg_vec   [CELLS];
   logic [3:0]                  reach_vec [CELLS];
   logic [gcmf_pkg::CAP_W-1:0]  dx_vec    [CELLS];
   logic [CELLS-1:0]            found_vec;
   logic [CELLS-1:0]            grow_vec;
   logic [CELLS-1:0]            done_vec;
   logic [CELLS-1:0]            tok_vec;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign busy      = (state_ff != gcmf_pkg::ST_IDLE);
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= gcmf_pkg::SIZE_W'(16);
         cols_cfg_ff <= gcmf_pkg::SIZE_W'(16);
         src_cap_ff  <= '0;
         sink_cap_ff <= '0;
         nbr_cap_ff  <= '0;
      end else if (csr_write) begin
         unique case (paddr[4:2])
            gcmf_pkg::REG_ROWS:     rows_cfg_ff <= pwdata[gcmf_pkg::SIZE_W-1:0];
            gcmf_pkg::REG_COLS:     cols_cfg_ff <= pwdata[gcmf_pkg::SIZE_W-1:0];
            gcmf_pkg::REG_SRC_CAP:  src_cap_ff  <= pwdata[gcmf_pkg::CAP_W-1:0];
            gcmf_pkg::REG_SINK_CAP: sink_cap_ff <= pwdata[gcmf_pkg::CAP_W-1:0];
            gcmf_pkg::REG_NBR_CAP:  nbr_cap_ff  <= pwdata[gcmf_pkg::CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         gcmf_pkg::REG_ROWS:     prdata = 32'(rows_cfg_ff);
         gcmf_pkg::REG_COLS:     prdata = 32'(cols_cfg_ff);
         gcmf_pkg::REG_SRC_CAP:  prdata = 32'(src_cap_ff);
         gcmf_pkg::REG_SINK_CAP: prdata = 32'(sink_cap_ff);
         gcmf_pkg::REG_NBR_CAP:  prdata = 32'(nbr_cap_ff);
         default:                prdata = '0;
      endcase
   end

   // out-of-range sizes clamp to the array: zero to one, oversized to the maximum
   always_comb begin
      if (rows_cfg_ff == '0) begin
         rows_eff = RW'(1);
      end else if (32'(rows_cfg_ff) > MAX_ROWS) begin
         rows_eff = RW'(MAX_ROWS);
      end else begin
         rows_eff = RW'(rows_cfg_ff);
      end
      if (cols_cfg_ff == '0) begin
         cols_eff = CW'(1);
      end else if (32'(cols_cfg_ff) > MAX_COLS) begin
         cols_eff = CW'(MAX_COLS);
      end else begin
         cols_eff = CW'(cols_cfg_ff);
      end
   end

   assign total    = NW'(rows_eff) * NW'(cols_eff);
   assign label_rd = (state_ff == gcmf_pkg::ST_COPY);

   logic label_q;

   gcmf_ram #(
      .WIDTH (1),
      .DEPTH (CELLS)
   ) u_label_ram (
      .clock (clock),
      .we    (accept),
      .waddr (count_ff[AW-1:0]),
      .wdata (req_is_black),
      .re    (label_rd),
      .raddr (rd_p_ff[AW-1:0]),
      .rdata (label_q)
   );

   always_comb begin
      any_found   = |found_vec;
      any_grow    = |grow_vec;
      any_done    = |done_vec;
      done_gather = '0;
      for (int i = 0; i < CELLS; i++) begin
         done_gather = done_gather | dx_vec[i];
      end
   end

   assign scan_hit = (state_ff == gcmf_pkg::ST_SCAN) && found_vec[scan_ff];

   always_comb begin
      ctrl          = '0;
      ctrl.src_cap  = src_cap_ff;
      ctrl.sink_cap = sink_cap_ff;
      ctrl.nbr_cap  = nbr_cap_ff;
      ctrl.init     = (state_ff == gcmf_pkg::ST_INIT);
      ctrl.seed     = (state_ff == gcmf_pkg::ST_SEED);
      ctrl.grow     = (state_ff == gcmf_pkg::ST_GROW) && !any_found && any_grow;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gcmf_pkg::ST_IDLE: begin
            if (accept && (({1'b0, count_ff} + 1'b1) >= {1'b0, total})) begin
               state_in = gcmf_pkg::ST_COPY;
            end
         end
         gcmf_pkg::ST_COPY: begin
            if (({1'b0, rd_p_ff} + 1'b1) >= {1'b0, total}) begin
               state_in = gcmf_pkg::ST_COPY_END;
            end
         end
         gcmf_pkg::ST_COPY_END: state_in = gcmf_pkg::ST_INIT;
         gcmf_pkg::ST_INIT:     state_in = gcmf_pkg::ST_SEED;
         gcmf_pkg::ST_SEED:     state_in = gcmf_pkg::ST_GROW;
         gcmf_pkg::ST_GROW: begin
            if (any_found) begin
               state_in = gcmf_pkg::ST_SCAN;
            end else if (!any_grow) begin
               state_in = gcmf_pkg::ST_IDLE;
            end
         end
         gcmf_pkg::ST_SCAN: begin
            if (scan_hit) begin
               state_in = gcmf_pkg::ST_TRACE;
            end
         end
         gcmf_pkg::ST_TRACE: begin
            if (any_done) begin
               state_in = gcmf_pkg::ST_SEED;
            end
         end
         default: state_in = gcmf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= gcmf_pkg::ST_IDLE;
         count_ff    <= '0;
         cp_valid_ff <= 1'b0;
         rsp_strobe  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cp_valid_ff <= (state_ff == gcmf_pkg::ST_COPY);
         rsp_strobe  <= (state_ff == gcmf_pkg::ST_GROW) && !any_found && !any_grow;
         if (accept) begin
            if (state_in == gcmf_pkg::ST_COPY) begin
               count_ff <= '0;
            end else begin
               count_ff <= count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cp_r_ff <= rd_r_ff;
      cp_c_ff <= rd_c_ff;
      if (state_ff == gcmf_pkg::ST_GROW && !any_found && !any_grow) begin
         rsp_max_flow <= flow_ff;
      end
      if (state_ff == gcmf_pkg::ST_IDLE) begin
         rd_p_ff <= '0;
         rd_r_ff <= '0;
         rd_c_ff <= '0;
         flow_ff <= '0;
      end else if (state_ff == gcmf_pkg::ST_COPY) begin
         // walk pixels in row-major order under the current column count
         rd_p_ff <= rd_p_ff + 1'b1;
         if (({1'b0, rd_c_ff} + 1'b1) >= {1'b0, cols_eff}) begin
            rd_c_ff <= '0;
            rd_r_ff <= rd_r_ff + 1'b1;
         end else begin
            rd_c_ff <= rd_c_ff + 1'b1;
         end
      end
      if (state_ff == gcmf_pkg::ST_GROW) begin
         scan_ff <= '0;
      end else if (state_ff == gcmf_pkg::ST_SCAN && !scan_hit) begin
         scan_ff <= scan_ff + 1'b1;
      end
      if (state_ff == gcmf_pkg::ST_TRACE && any_done) begin
         flow_ff <= flow_ff + gcmf_pkg::FLOW_W'(done_gather);
      end
   end

   for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
      for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
         localparam int unsigned IDX = r * MAX_COLS + c;
         gcmf_pkg::msg_type [3:0] nmsg;
         logic [3:0]              nreach;
         logic                    lwe;
         logic                    cstart;

         if (r > 0) begin : g_up
            assign nmsg[gcmf_pkg::DIR_UP]   = msg_vec[IDX - MAX_COLS];
            assign nreach[gcmf_pkg::DIR_UP] = reach_vec[IDX - MAX_COLS][gcmf_pkg::DIR_DOWN];
         end else begin : g_no_up
            assign nmsg[gcmf_pkg::DIR_UP]   = '0;
            assign nreach[gcmf_pkg::DIR_UP] = 1'b0;
         end
         if (r + 1 < MAX_ROWS) begin : g_down
            assign nmsg[gcmf_pkg::DIR_DOWN]   = msg_vec[IDX + MAX_COLS];
            assign nreach[gcmf_pkg::DIR_DOWN] = reach_vec[IDX + MAX_COLS][gcmf_pkg::DIR_UP];
         end else begin : g_no_down
            assign nmsg[gcmf_pkg::DIR_DOWN]   = '0;
            assign nreach[gcmf_pkg::DIR_DOWN] = 1'b0;
         end
         if (c > 0) begin : g_left
            assign nmsg[gcmf_pkg::DIR_LEFT]   = msg_vec[IDX - 1];
            assign nreach[gcmf_pkg::DIR_LEFT] = reach_vec[IDX - 1][gcmf_pkg::DIR_RIGHT];
         end else begin : g_no_left
            assign nmsg[gcmf_pkg::DIR_LEFT]   = '0;
            assign nreach[gcmf_pkg::DIR_LEFT] = 1'b0;
         end
         if (c + 1 < MAX_COLS) begin : g_right
            assign nmsg[gcmf_pkg::DIR_RIGHT]   = msg_vec[IDX + 1];
            assign nreach[gcmf_pkg::DIR_RIGHT] = reach_vec[IDX + 1][gcmf_pkg::DIR_LEFT];
         end else begin : g_no_right
            assign nmsg[gcmf_pkg::DIR_RIGHT]   = '0;
            assign nreach[gcmf_pkg::DIR_RIGHT] = 1'b0;
         end

         assign lwe          = cp_valid_ff && (cp_r_ff == RW'(r)) && (cp_c_ff == CW'(c));
         assign cstart       = scan_hit && (scan_ff == AW'(IDX));
         assign tok_vec[IDX] = msg_vec[IDX].valid;

         gcmf_cell #(
            .ROW_W   (RW),
            .COL_W   (CW),
            .ROW_POS (r),
            .COL_POS (c)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .rows      (rows_eff),
            .cols      (cols_eff),
            .label_we  (lwe),
            .label_in  (label_q),
            .start     (cstart),
            .msg_in    (nmsg),
            .reach_in  (nreach),
            .msg_out   (msg_vec[IDX]),
            .reach_out (reach_vec[IDX]),
            .found     (found_vec[IDX]),
            .grow_cand (grow_vec[IDX]),
            .done      (done_vec[IDX]),
            .done_x    (dx_vec[IDX])
         );
      end
   end

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one path token in the cell array");

   a_done_in_trace: assert property (@(posedge clock) disable iff (reset)
      (|done_vec) |-> (state_ff == gcmf_pkg::ST_TRACE))
      else $error("augment finished outside of the trace phase");

   a_strobe_after_search: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == gcmf_pkg::ST_GROW))
      else $error("result without an exhausted search");

endmodule
`default_nettype wire

// File: test/tb_top.sv
`default_nettype none
module tb_top;

   localparam int unsigned IDLE_LIMIT = 20000000;
   localparam int unsigned TARGET_PIXELS = 1150;

   // predicts the minimum cut of each finished grid and checks the flow results
   class cut_scoreboard;
      int unsigned rows_reg, cols_reg;
      int unsigned src_cap, sink_cap, nbr_cap;
      int unsigned pixel_count;
      bit label[256];
      logic [23:0] flow_queue[$];
      int unsigned errors, grids, pixels;

      function new();
         rows_reg = 16; cols_reg = 16;
         src_cap = 0; sink_cap = 0; nbr_cap = 0;
         pixel_count = 0; errors = 0; grids = 0; pixels = 0;
      endfunction

      function int unsigned clamp_dim(int unsigned v);
         if (v < 1) return 1;
         if (v > 16) return 16;
         return v;
      endfunction

      function int unsigned grid_pixels();
         return clamp_dim(rows_reg) * clamp_dim(cols_reg);
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] value);
         case (gcmf_pkg::reg_type'(idx))
            gcmf_pkg::REG_ROWS:     rows_reg = value[4:0];
            gcmf_pkg::REG_COLS:     cols_reg = value[4:0];
            gcmf_pkg::REG_SRC_CAP:  src_cap = value[15:0];
            gcmf_pkg::REG_SINK_CAP: sink_cap = value[15:0];
            gcmf_pkg::REG_NBR_CAP:  nbr_cap = value[15:0];
            default: ;
         endcase
      endfunction

      function int neighbor(int u, int d, int cols);
         case (d)
            gcmf_pkg::DIR_UP:   return u - cols;
            gcmf_pkg::DIR_DOWN: return u + cols;
            gcmf_pkg::DIR_LEFT: return u - 1;
            default:            return u + 1;
         endcase
      endfunction

      // shortest augmenting paths over the residual grid
      function logic [23:0] min_cut(int rows, int cols);
         int unsigned tres[256];
         int unsigned nres[1024];
         int q[256];
         int from[256];
         bit seen[256];
         int total, head, tail, u, w, v, p, r, c, d, dd, tip;
         int unsigned x;
         longint unsigned flow;
         bit found;
         total = rows * cols;
         flow = 0;
         for (p = 0; p < total; p++) begin
            r = p / cols; c = p % cols;
            tres[p] = label[p] ? sink_cap : src_cap;
            nres[p*4+0] = (r > 0) ? nbr_cap : 0;
            nres[p*4+1] = (r + 1 < rows) ? nbr_cap : 0;
            nres[p*4+2] = (c > 0) ? nbr_cap : 0;
            nres[p*4+3] = (c + 1 < cols) ? nbr_cap : 0;
         end
         forever begin
            head = 0; tail = 0; found = 0; tip = 0;
            for (p = 0; p < total; p++) begin
               seen[p] = 0;
               if (!label[p] && tres[p] > 0) begin
                  seen[p] = 1; from[p] = 4; q[tail++] = p;
               end
            end
            while (head < tail && !found) begin
               u = q[head++];
               if (label[u] && tres[u] > 0) begin
                  found = 1; tip = u;
               end else begin
                  for (d = 0; d < 4; d++) begin
                     if (nres[u*4+d] > 0) begin
                        w = neighbor(u, d, cols);
                        if (w >= 0 && w < total && !seen[w]) begin
                           seen[w] = 1; from[w] = d; q[tail++] = w;
                        end
                     end
                  end
               end
            end
            if (!found) break;
            x = tres[tip];
            v = tip;
            while (from[v] != 4) begin
               dd = from[v];
               u = neighbor(v, dd ^ 1, cols);
               if (nres[u*4+dd] < x) x = nres[u*4+dd];
               v = u;
            end
            if (tres[v] < x) x = tres[v];
            tres[tip] -= x;
            v = tip;
            while (from[v] != 4) begin
               dd = from[v];
               u = neighbor(v, dd ^ 1, cols);
               nres[u*4+dd] -= x;
               nres[v*4+(dd^1)] += x;
               v = u;
            end
            tres[v] -= x;
            flow += x;
         end
         return flow[23:0];
      endfunction

      function void note_pixel(bit black);
         int unsigned total;
         total = grid_pixels();
         pixels++;
         if (pixel_count < 256) label[pixel_count] = black;
         pixel_count++;
         if (pixel_count >= total) begin
            flow_queue.push_back(min_cut(clamp_dim(rows_reg), clamp_dim(cols_reg)));
            pixel_count = 0;
         end
      endfunction

      function void check_flow(logic [23:0] actual);
         logic [23:0] want;
         if (flow_queue.size() == 0) begin
            $display("%0t: unexpected flow result, expected none, actual %0d", $time, actual);
            errors++;
         end else begin
            want = flow_queue.pop_front();
            grids++;
            if (actual !== want) begin
               $display("%0t: max_flow mismatch, expected %0d, actual %0d",
                        $time, want, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_is_black = 0;
   logic        rsp_strobe;
   logic [23:0] rsp_max_flow;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [4:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   cut_scoreboard cuts = new();
   int unsigned idle_cycles = 0;
   int unsigned csr_writes = 0;
   int unsigned sent = 0;

   grid_graph_cut_max_flow dut (
      .clock, .reset, .start, .busy, .req_is_black, .rsp_strobe, .rsp_max_flow,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_strobe) begin
            cuts.check_flow(rsp_max_flow);
            moved = 1'b1;
         end
         if (start && !busy) begin
            cuts.note_pixel(req_is_black);
            moved = 1'b1;
         end
         if (psel && penable && pwrite && pready) begin
            cuts.write_reg(paddr[4:2], pwdata);
            csr_writes++;
            moved = 1'b1;
         end
         if (moved) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_pixel(bit black);
      start = 1;
      req_is_black = black;
      do @(posedge clock); while (busy);
      @(negedge clock);
      sent++;
   endtask

   task automatic random_gap();
      int unsigned n, roll;
      roll = $urandom_range(99);
      if (roll < 65) n = 0;
      else if (roll < 93) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 40);
      if (n > 0) begin
         start = 0;
         req_is_black = 1'($urandom_range(1));
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic csr_write(gcmf_pkg::reg_type idx, logic [31:0] value);
      start = 0;
      psel = 1; penable = 0; pwrite = 1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
   endtask

   task automatic wait_quiet();
      start = 0;
      while (cuts.flow_queue.size() > 0 || busy) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_grid(logic [31:0] r, logic [31:0] c, logic [31:0] s,
                           logic [31:0] k, logic [31:0] n);
      wait_quiet();
      csr_write(gcmf_pkg::REG_ROWS, r);
      csr_write(gcmf_pkg::REG_COLS, c);
      csr_write(gcmf_pkg::REG_SRC_CAP, s);
      csr_write(gcmf_pkg::REG_SINK_CAP, k);
      csr_write(gcmf_pkg::REG_NBR_CAP, n);
   endtask

   function automatic logic [31:0] pick_cap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 12) return 32'd0;
      if (roll < 25) return {16'($urandom_range(65535)), 16'hFFFF};
      if (roll < 45) return $urandom_range(1, 9);
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_dim();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 3) return 32'd16;
      if (roll < 5) return 32'd0;
      if (roll < 7) return $urandom_range(17, 31) | ($urandom << 5);
      return $urandom_range(1, 6);
   endfunction

   initial begin
      int unsigned i, n, bias;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // single pixel grids, either label
      set_grid(1, 1, 32'hFFFF, 32'hFFFF, 32'hFFFF);
      send_pixel(0);
      send_pixel(1);
      // two pixels, full capacity, then a blocked neighbor edge
      set_grid(1, 2, 32'hFFFF, 32'hFFFF, 32'hFFFF);
      send_pixel(0);
      send_pixel(1);
      set_grid(2, 1, 32'hFFFF_FFFF, 32'h0001_FFFF, 32'h0);
      send_pixel(1);
      send_pixel(0);
      // zero rows clamps to one, oversized columns clamp to the maximum
      set_grid(0, 31, 32'd700, 32'd300, 32'd50);
      for (i = 0; i < 16; i++) send_pixel(i[0]);
      // shrink the grid mid-way so the next pixel completes it at once
      set_grid(2, 2, 32'd9, 32'd5, 32'd3);
      send_pixel(0);
      send_pixel(1);
      send_pixel(0);
      wait_quiet();
      csr_write(gcmf_pkg::REG_ROWS, 1);
      csr_write(gcmf_pkg::REG_COLS, 2);
      send_pixel(1);

      while (sent < TARGET_PIXELS) begin
         // every grid starts from an idle block with fresh settings
         set_grid(pick_dim(), pick_dim(), pick_cap(), pick_cap(), pick_cap());
         if ($urandom_range(99) < 4) begin
            csr_write(gcmf_pkg::REG_ROWS, 16);
            csr_write(gcmf_pkg::REG_COLS, 16);
         end
         n = cuts.grid_pixels();
         bias = $urandom_range(100);
         if ($urandom_range(3) == 0) bias = 50;
         for (i = 0; i < n; i++) begin
            random_gap();
            send_pixel($urandom_range(99) < bias);
         end
      end

      wait_quiet();
      repeat (40) @(negedge clock);
      $display("sent %0d pixels over %0d solved grids with %0d register writes",
               sent, cuts.grids, csr_writes);
      $display("grid sizes 1x1 to 16x16, capacities from zero to full scale");
      if (cuts.errors == 0 && cuts.flow_queue.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: filelist.f
hdl/gcmf_pkg.sv
hdl/gcmf_ram.sv
hdl/gcmf_cell.sv
hdl/grid_graph_cut_max_flow.sv
test/tb_top.sv
